// ===== design/bafb_pkg.sv =====
// Shared types and constants of the fused bias, activation, gain and clamp block.
package bafb_pkg;

   localparam int SLOPE_FRAC = 8;
   localparam int SLOPE_W    = 8;
   localparam int GAIN_W     = 16;
   localparam int CLIP_W     = 15;
   localparam int BG_W       = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ACT_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_NEG   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LEVEL  = 3'd4;

   localparam logic               RST_ACT_MODE    = 1'b0;
   localparam logic [SLOPE_W-1:0] RST_SLOPE_NEG   = 8'd51;
   localparam logic [GAIN_W-1:0]  RST_GAIN_FACTOR = 16'd256;
   localparam logic               RST_CLIP_ENABLE = 1'b0;
   localparam logic [CLIP_W-1:0]  RST_CLIP_LEVEL  = 15'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_Y,
      ST_MUL_D,
      ST_MUL_S,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_T_SLOPE,
      MUL_A_GAIN,
      MUL_DY_GAIN,
      MUL_DT_SLOPE
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        cap_y;
      logic        cap_d;
      logic        finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctl_status_type;

endpackage

// ===== design/bias_act_forward_backward.sv =====
// The single shared multiplier runs four products in turn (slope, gain, gradient gain,
// gradient slope) before the final step, which writes the result to the output register;
// a new transaction is accepted only once the block is back in its idle state.
// The output register holds a result while the next transaction is accepted.
// Reset (synchronous, active high) restores the register defaults and clears the
// channel accumulator and the output valid.
module bias_act_forward_backward #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8,
   parameter int ACC_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bafb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bafb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [DATA_WIDTH-1:0]        req_x_value,
   input  logic signed [DATA_WIDTH-1:0]        req_bias_value,
   input  logic signed [DATA_WIDTH-1:0]        req_grad_in,
   input  logic                                req_last_in_channel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [DATA_WIDTH-1:0]        rsp_elem_out,
   output logic signed [bafb_pkg::BG_W-1:0]    rsp_bias_grad,
   output logic                                rsp_bias_grad_valid
);
   import bafb_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   bafb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bafb_dpath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .ACC_WIDTH  (ACC_WIDTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_op              (req_op),
      .req_x_value         (req_x_value),
      .req_bias_value      (req_bias_value),
      .req_grad_in         (req_grad_in),
      .req_last_in_channel (req_last_in_channel),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_elem_out        (rsp_elem_out),
      .rsp_bias_grad       (rsp_bias_grad),
      .rsp_bias_grad_valid (rsp_bias_grad_valid)
   );

endmodule

// ===== design/bafb_ctrl.sv =====
// Controller state machine that sequences the shared multiplier of the datapath.
module bafb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bafb_pkg::ctl_status_type status,
   output bafb_pkg::ctl_cmd_type   cmd
);
   import bafb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_MUL_S;
         ST_MUL_S:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_T_SLOPE;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_MUL_A: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_T_SLOPE;
         end
         ST_MUL_Y: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_A_GAIN;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DY_GAIN;
            cmd.cap_y   = 1'b1;
         end
         ST_MUL_S: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DT_SLOPE;
            cmd.cap_d   = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // An accepted transaction always starts the multiply sequence.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL_A))
      else $error("accepted transaction did not start the sequence");

   // A result waits in the final state until the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !status.out_free) |=> (state_ff == ST_FINISH))
      else $error("result left the final state while the output was blocked");

   // The last multiply step is always followed by the final state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_S) |=> (state_ff == ST_FINISH))
      else $error("sequence skipped the final state");

endmodule

// ===== design/bafb_dpath.sv =====
// Datapath: configuration registers, shared multiplier, clamp, saturation and accumulator.
module bafb_dpath #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8,
   parameter int ACC_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bafb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bafb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_op,
   input  logic signed [DATA_WIDTH-1:0]        req_x_value,
   input  logic signed [DATA_WIDTH-1:0]        req_bias_value,
   input  logic signed [DATA_WIDTH-1:0]        req_grad_in,
   input  logic                                req_last_in_channel,
   input  bafb_pkg::ctl_cmd_type               cmd,
   output bafb_pkg::ctl_status_type            status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [DATA_WIDTH-1:0]        rsp_elem_out,
   output logic signed [bafb_pkg::BG_W-1:0]    rsp_bias_grad,
   output logic                                rsp_bias_grad_valid
);
   import bafb_pkg::*;

   localparam int TW    = DATA_WIDTH + 1;
   localparam int DTW   = DATA_WIDTH + GAIN_W - FRAC_BITS;
   localparam int YW    = DATA_WIDTH + GAIN_W + 1 - FRAC_BITS;
   localparam int MA_W  = (DTW > TW) ? DTW : TW;
   localparam int MB_W  = GAIN_W + 1;
   localparam int PW    = MA_W + MB_W;
   localparam int CW    = ((YW > CLIP_W + 1) ? YW : CLIP_W + 1) + 1;
   localparam int SW    = ACC_WIDTH + 1;
   localparam int XW    = (ACC_WIDTH > BG_W) ? ACC_WIDTH : BG_W + 1;

   // Configuration registers.
   logic               act_mode_ff;
   logic [SLOPE_W-1:0] slope_neg_ff;
   logic [GAIN_W-1:0]  gain_factor_ff;
   logic               clip_enable_ff;
   logic [CLIP_W-1:0]  clip_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_mode_ff    <= RST_ACT_MODE;
         slope_neg_ff   <= RST_SLOPE_NEG;
         gain_factor_ff <= RST_GAIN_FACTOR;
         clip_enable_ff <= RST_CLIP_ENABLE;
         clip_level_ff  <= RST_CLIP_LEVEL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACT_MODE:    act_mode_ff    <= csr_wdata[0];
            CSR_SLOPE_NEG:   slope_neg_ff   <= csr_wdata[SLOPE_W-1:0];
            CSR_GAIN_FACTOR: gain_factor_ff <= csr_wdata[GAIN_W-1:0];
            CSR_CLIP_ENABLE: clip_enable_ff <= csr_wdata[0];
            CSR_CLIP_LEVEL:  clip_level_ff  <= csr_wdata[CLIP_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand registers of the transaction in flight.
   logic                   op_ff;
   logic                   last_ff;
   logic signed [TW-1:0]   t_ff;
   logic signed [DATA_WIDTH-1:0] dy_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [PW-1:0]   prod_in;
   logic signed [YW-1:0]   ypre_ff;
   logic signed [DTW-1:0]  dt_ff;
   logic signed [ACC_WIDTH-1:0] accum_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         last_ff <= req_last_in_channel;
         t_ff    <= TW'(req_x_value) + TW'(req_bias_value);
         dy_ff   <= req_grad_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.cap_y) begin
         ypre_ff <= prod_ff[FRAC_BITS +: YW];
      end
      if (cmd.cap_d) begin
         dt_ff <= prod_ff[FRAC_BITS +: DTW];
      end
   end

   // Zero counts as the negative side of the leaky ReLU.
   logic neg_side;
   assign neg_side = act_mode_ff && !(t_ff > 0);

   logic signed [TW-1:0]   a_cur;
   logic signed [TW-1:0]   a_sel;
   logic signed [DTW-1:0]  dt_cur;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;

   assign a_cur  = prod_ff[SLOPE_FRAC +: TW];
   assign a_sel  = neg_side ? a_cur : t_ff;
   assign dt_cur = prod_ff[FRAC_BITS +: DTW];

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_T_SLOPE: begin
            mul_a = MA_W'(t_ff);
            mul_b = MB_W'(slope_neg_ff);
         end
         MUL_A_GAIN: begin
            mul_a = MA_W'(a_sel);
            mul_b = MB_W'(gain_factor_ff);
         end
         MUL_DY_GAIN: begin
            mul_a = MA_W'(dy_ff);
            mul_b = MB_W'(gain_factor_ff);
         end
         MUL_DT_SLOPE: begin
            mul_a = MA_W'(dt_cur);
            mul_b = MB_W'(slope_neg_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // The product is formed at the full product width.
   assign prod_in = mul_a * mul_b;

   // Forward: clip against the clamp level when the clamp is enabled, then saturate.
   logic signed [CW-1:0] ypre_c;
   logic signed [CW-1:0] lim_c;
   logic signed [CW-1:0] nlim_c;
   logic signed [CW-1:0] y_clip;
   logic                 above;
   logic                 below;
   logic signed [DATA_WIDTH-1:0] y_sat;

   assign ypre_c = CW'(ypre_ff);
   assign lim_c  = CW'({1'b0, clip_level_ff});
   assign nlim_c = -lim_c;
   assign above  = ypre_c > lim_c;
   assign below  = ypre_c < nlim_c;

   always_comb begin
      y_clip = ypre_c;
      if (clip_enable_ff) begin
         priority if (below) begin
            y_clip = nlim_c;
         end else if (above) begin
            y_clip = lim_c;
         end else begin
            y_clip = ypre_c;
         end
      end
   end

   always_comb begin
      if ((&y_clip[CW-1:DATA_WIDTH-1]) || !(|y_clip[CW-1:DATA_WIDTH-1])) begin
         y_sat = y_clip[DATA_WIDTH-1:0];
      end else begin
         y_sat = {y_clip[CW-1], {(DATA_WIDTH-1){!y_clip[CW-1]}}};
      end
   end

   // Backward: apply the slope where needed, mask outside the clamp, saturate.
   logic signed [DTW-1:0]        dt_fin;
   logic signed [DTW-1:0]        dt_mask;
   logic signed [DATA_WIDTH-1:0] dt_sat;

   assign dt_fin  = neg_side ? prod_ff[SLOPE_FRAC +: DTW] : dt_ff;
   assign dt_mask = (clip_enable_ff && (above || below)) ? '0 : dt_fin;

   always_comb begin
      if ((&dt_mask[DTW-1:DATA_WIDTH-1]) || !(|dt_mask[DTW-1:DATA_WIDTH-1])) begin
         dt_sat = dt_mask[DATA_WIDTH-1:0];
      end else begin
         dt_sat = {dt_mask[DTW-1], {(DATA_WIDTH-1){!dt_mask[DTW-1]}}};
      end
   end

   // Channel accumulator with saturation.
   logic signed [SW-1:0]        acc_sum;
   logic signed [ACC_WIDTH-1:0] acc_new;
   logic signed [XW-1:0]        acc_x;
   logic signed [BG_W-1:0]      bg_sat;

   assign acc_sum = SW'(accum_ff) + SW'(dt_sat);

   always_comb begin
      if (acc_sum[SW-1] == acc_sum[SW-2]) begin
         acc_new = acc_sum[ACC_WIDTH-1:0];
      end else begin
         acc_new = {acc_sum[SW-1], {(ACC_WIDTH-1){!acc_sum[SW-1]}}};
      end
   end

   assign acc_x = XW'(acc_new);

   always_comb begin
      if ((&acc_x[XW-1:BG_W-1]) || !(|acc_x[XW-1:BG_W-1])) begin
         bg_sat = acc_x[BG_W-1:0];
      end else begin
         bg_sat = {acc_x[XW-1], {(BG_W-1){!acc_x[XW-1]}}};
      end
   end

   logic backward_done;
   assign backward_done = cmd.finish && op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
      end else if (backward_done) begin
         accum_ff <= last_ff ? '0 : acc_new;
      end
   end

   // Output register; it frees as soon as the current result is taken.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] elem_ff;
   logic signed [BG_W-1:0]       bg_ff;
   logic                         bgv_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         elem_ff <= op_ff ? dt_sat : y_sat;
         bg_ff   <= (op_ff && last_ff) ? bg_sat : '0;
         bgv_ff  <= op_ff && last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_elem_out        = elem_ff;
   assign rsp_bias_grad       = bg_ff;
   assign rsp_bias_grad_valid = bgv_ff;

   // A finished channel clears the accumulator.
   assert property (@(posedge clock) disable iff (reset)
      (backward_done && last_ff) |=> (accum_ff == '0))
      else $error("accumulator not cleared at end of channel");

   // Forward transactions leave the accumulator alone.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !op_ff) |=> $stable(accum_ff))
      else $error("forward transaction changed the accumulator");

   // A loaded result is never marked as a channel sum unless it is backward.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !op_ff) |=> (rsp_valid && !rsp_bias_grad_valid))
      else $error("forward result flagged as channel sum");

endmodule
